@@ sv/m3inv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package m3inv_pkg;

    localparam int DW = 64;

    typedef struct packed {
        logic [DW-1:0] m00;
        logic [DW-1:0] m01;
        logic [DW-1:0] m02;
        logic [DW-1:0] m10;
        logic [DW-1:0] m11;
        logic [DW-1:0] m12;
        logic [DW-1:0] m20;
        logic [DW-1:0] m21;
        logic [DW-1:0] m22;
    } mat_t;

    typedef struct packed {
        logic [DW-1:0] r00;
        logic [DW-1:0] r01;
        logic [DW-1:0] r02;
        logic [DW-1:0] r10;
        logic [DW-1:0] r11;
        logic [DW-1:0] r12;
        logic [DW-1:0] r20;
        logic [DW-1:0] r21;
        logic [DW-1:0] r22;
        logic          singular;
        logic          overflow;
    } inv_t;

endpackage

`default_nettype wire

@@ sv/matrix3_inverse_fixed_point.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake             beat payload
// mat      in   mat_valid / mat_stall  m3inv_pkg::mat_t (nine signed words)
// inv      out  inv_valid / inv_stall  m3inv_pkg::inv_t (nine words, singular, overflow)
//
// One matrix per cycle while mat_stall is low; inv_valid rises once the mat beat
// has passed the cofactor, determinant, divider and scaling registers.
// Depth is set by the reciprocal divider, one quotient bit per stage.
// Reset clears the valid bits of the pipe, the output register and the skid entry.
// A beat that arrives while inv is stalled parks in one skid entry; mat_stall rises only while it is full.

module matrix3_inverse_fixed_point #(
    parameter int WORD_BITS = 64,
    parameter int FRAC_BITS = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             mat_valid,
    output logic                  mat_stall,
    input  wire m3inv_pkg::mat_t  mat,
    output logic                  inv_valid,
    input  wire logic             inv_stall,
    output m3inv_pkg::inv_t       inv
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int H  = (W + 1) / 2;
    localparam int HH = 2 * H;
    localparam int P  = 4 * H;
    localparam int QW = 2 * F + 1;
    localparam int SW = (P > QW + 1) ? P : QW + 1;
    localparam int NV = QW + 15;

    localparam int CA [18] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
    localparam int CB [18] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

    typedef logic signed [W-1:0] word_t;

    typedef struct packed {
        logic                 neg;
        logic [3:0][HH-1:0]   pp;
    } mpp_t;

    typedef struct packed {
        logic         neg;
        logic [P-1:0] mag;
    } msum_t;

    typedef struct packed {
        logic  ovf;
        word_t v;
    } satw_t;

    typedef struct packed {
        logic [W-1:0]        r;
        logic [QW-1:0]       q;
        logic [W-1:0]        md;
        logic                neg;
        logic                sing;
        logic                ovf;
        logic [8:0][W-1:0]   a;
    } div_t;

    localparam word_t MAX_W = {1'b0, {(W-1){1'b1}}};
    localparam word_t MIN_W = {1'b1, {(W-1){1'b0}}};
    localparam word_t ONE_W = (F <= W - 2) ? W'(64'd1 << F) : MAX_W;

    function automatic logic signed [SW-1:0] sx(word_t v);
        return SW'(v);
    endfunction

    function automatic logic [m3inv_pkg::DW-1:0] ext64(word_t v);
        return m3inv_pkg::DW'(v);
    endfunction

    function automatic satw_t sat_w(logic signed [SW-1:0] x);
        satw_t        r;
        logic [SW-W:0] top;
        top = x[SW-1:W-1];
        if ((&top) || !(|top)) begin
            r.ovf = 1'b0;
            r.v   = x[W-1:0];
        end else begin
            r.ovf = 1'b1;
            r.v   = x[SW-1] ? MIN_W : MAX_W;
        end
        return r;
    endfunction

    function automatic mpp_t mul_pp(word_t a, word_t b);
        mpp_t          r;
        logic [W-1:0]  ua;
        logic [W-1:0]  ub;
        logic [HH-1:0] ma;
        logic [HH-1:0] mb;
        ua = a[W-1] ? W'(-a) : W'(a);
        ub = b[W-1] ? W'(-b) : W'(b);
        ma = HH'(ua);
        mb = HH'(ub);
        r.neg   = a[W-1] ^ b[W-1];
        r.pp[0] = HH'(ma[H-1:0]) * HH'(mb[H-1:0]);
        r.pp[1] = HH'(ma[H-1:0]) * HH'(mb[HH-1:H]);
        r.pp[2] = HH'(ma[HH-1:H]) * HH'(mb[H-1:0]);
        r.pp[3] = HH'(ma[HH-1:H]) * HH'(mb[HH-1:H]);
        return r;
    endfunction

    function automatic msum_t mul_sum(mpp_t x);
        msum_t s;
        s.neg = x.neg;
        s.mag = P'(x.pp[0]) + ((P'(x.pp[1]) + P'(x.pp[2])) << H)
              + (P'(x.pp[3]) << HH);
        return s;
    endfunction

    function automatic satw_t mul_fin(msum_t s);
        logic signed [P-1:0] p;
        logic signed [P-1:0] sh;
        p  = s.neg ? -signed'(s.mag) : signed'(s.mag);
        sh = p >>> F;
        return sat_w(SW'(sh));
    endfunction

    function automatic div_t div_step(div_t x, logic seed);
        div_t         y;
        logic [W-1:0] rn;
        y  = x;
        rn = {x.r[W-2:0], seed};
        if (rn >= x.md) begin
            y.r = rn - x.md;
            y.q = {x.q[QW-2:0], 1'b1};
        end else begin
            y.r = rn;
            y.q = {x.q[QW-2:0], 1'b0};
        end
        return y;
    endfunction

    logic          adv;
    logic [NV-1:0] vld_reg;

    word_t in_m_reg  [9];
    word_t in_m_next [9];

    mpp_t  c1_pp_reg  [18];
    mpp_t  c1_pp_next [18];
    word_t c1_m_reg   [3];
    msum_t c2_sum_reg  [18];
    msum_t c2_sum_next [18];
    word_t c2_m_reg    [3];
    word_t c3_p_reg    [18];
    word_t c3_p_next   [18];
    logic  c3_ovf_reg;
    logic  c3_ovf_next;
    word_t c3_m_reg    [3];
    word_t c4_a_reg    [9];
    word_t c4_a_next   [9];
    logic  c4_ovf_reg;
    logic  c4_ovf_next;
    word_t c4_m_reg    [3];

    mpp_t  d1_pp_reg   [3];
    mpp_t  d1_pp_next  [3];
    word_t d1_a_reg    [9];
    logic  d1_ovf_reg;
    msum_t d2_sum_reg  [3];
    msum_t d2_sum_next [3];
    word_t d2_a_reg    [9];
    logic  d2_ovf_reg;
    word_t d3_p_reg    [3];
    word_t d3_p_next   [3];
    word_t d3_a_reg    [9];
    logic  d3_ovf_reg;
    logic  d3_ovf_next;
    word_t d4_s01_reg;
    word_t d4_s01_next;
    word_t d4_p2_reg;
    word_t d4_a_reg    [9];
    logic  d4_ovf_reg;
    logic  d4_ovf_next;
    word_t d5_det_reg;
    word_t d5_det_next;
    word_t d5_a_reg    [9];
    logic  d5_ovf_reg;
    logic  d5_ovf_next;

    div_t  dv_reg  [0:QW];
    div_t  dv_next [0:QW];

    word_t rc_inv_reg;
    word_t rc_inv_next;
    word_t rc_a_reg    [9];
    word_t rc_a_next   [9];
    logic  rc_ovf_reg;
    logic  rc_ovf_next;
    logic  rc_sing_reg;

    mpp_t  f1_pp_reg   [9];
    mpp_t  f1_pp_next  [9];
    logic  f1_ovf_reg;
    logic  f1_sing_reg;
    msum_t f2_sum_reg  [9];
    msum_t f2_sum_next [9];
    logic  f2_ovf_reg;
    logic  f2_sing_reg;
    word_t f3_r_reg    [9];
    word_t f3_r_next   [9];
    logic  f3_ovf_reg;
    logic  f3_ovf_next;
    logic  f3_sing_reg;

    m3inv_pkg::inv_t res;
    m3inv_pkg::inv_t out_reg;
    m3inv_pkg::inv_t skid_reg;
    logic            out_v_reg;
    logic            skid_v_reg;
    logic            take;

    assign adv       = !skid_v_reg;
    assign mat_stall = skid_v_reg;
    assign take      = out_v_reg && !inv_stall;
    assign inv_valid = out_v_reg;
    assign inv       = out_reg;

    always_comb
    begin
        in_m_next[0] = mat.m00[W-1:0];
        in_m_next[1] = mat.m01[W-1:0];
        in_m_next[2] = mat.m02[W-1:0];
        in_m_next[3] = mat.m10[W-1:0];
        in_m_next[4] = mat.m11[W-1:0];
        in_m_next[5] = mat.m12[W-1:0];
        in_m_next[6] = mat.m20[W-1:0];
        in_m_next[7] = mat.m21[W-1:0];
        in_m_next[8] = mat.m22[W-1:0];
    end

    // cofactor products and their differences
    always_comb
    begin
        satw_t t;
        for (int k = 0; k < 18; k++) begin
            c1_pp_next[k]  = mul_pp(in_m_reg[CA[k]], in_m_reg[CB[k]]);
            c2_sum_next[k] = mul_sum(c1_pp_reg[k]);
        end
        c3_ovf_next = 1'b0;
        for (int k = 0; k < 18; k++) begin
            t            = mul_fin(c2_sum_reg[k]);
            c3_p_next[k] = t.v;
            c3_ovf_next  = c3_ovf_next | t.ovf;
        end
        c4_ovf_next = c3_ovf_reg;
        for (int k = 0; k < 9; k++) begin
            t            = sat_w(sx(c3_p_reg[2*k]) - sx(c3_p_reg[2*k+1]));
            c4_a_next[k] = t.v;
            c4_ovf_next  = c4_ovf_next | t.ovf;
        end
    end

    // determinant along the first row
    always_comb
    begin
        satw_t t;
        d1_pp_next[0] = mul_pp(c4_m_reg[0], c4_a_reg[0]);
        d1_pp_next[1] = mul_pp(c4_m_reg[1], c4_a_reg[3]);
        d1_pp_next[2] = mul_pp(c4_m_reg[2], c4_a_reg[6]);
        d3_ovf_next   = d2_ovf_reg;
        for (int k = 0; k < 3; k++) begin
            d2_sum_next[k] = mul_sum(d1_pp_reg[k]);
            t              = mul_fin(d2_sum_reg[k]);
            d3_p_next[k]   = t.v;
            d3_ovf_next    = d3_ovf_next | t.ovf;
        end
        t           = sat_w(sx(d3_p_reg[0]) + sx(d3_p_reg[1]));
        d4_s01_next = t.v;
        d4_ovf_next = d3_ovf_reg | t.ovf;
        t           = sat_w(sx(d4_s01_reg) + sx(d4_p2_reg));
        d5_det_next = t.v;
        d5_ovf_next = d4_ovf_reg | t.ovf;
    end

    // divider setup: magnitude of the determinant
    always_comb
    begin
        dv_next[0].r    = '0;
        dv_next[0].q    = '0;
        dv_next[0].md   = d5_det_reg[W-1] ? W'(-d5_det_reg) : W'(d5_det_reg);
        dv_next[0].neg  = d5_det_reg[W-1];
        dv_next[0].sing = (d5_det_reg == '0);
        dv_next[0].ovf  = d5_ovf_reg;
        for (int k = 0; k < 9; k++) begin
            dv_next[0].a[k] = d5_a_reg[k];
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        assign dv_next[j+1] = div_step(dv_reg[j], (j == 0));
    end

    // reciprocal sign and range
    always_comb
    begin
        logic signed [SW-1:0] qx;
        satw_t                t;
        qx = SW'({1'b0, dv_reg[QW].q});
        qx = dv_reg[QW].neg ? -qx : qx;
        t  = sat_w(qx);
        rc_inv_next = t.v;
        rc_ovf_next = dv_reg[QW].ovf | t.ovf;
        for (int k = 0; k < 9; k++) begin
            rc_a_next[k] = dv_reg[QW].a[k];
        end
    end

    // adjugate times reciprocal
    always_comb
    begin
        satw_t t;
        f3_ovf_next = f2_ovf_reg;
        for (int k = 0; k < 9; k++) begin
            f1_pp_next[k]  = mul_pp(rc_a_reg[k], rc_inv_reg);
            f2_sum_next[k] = mul_sum(f1_pp_reg[k]);
            t              = mul_fin(f2_sum_reg[k]);
            f3_r_next[k]   = t.v;
            f3_ovf_next    = f3_ovf_next | t.ovf;
        end
    end

    always_comb
    begin
        res.r00      = ext64(f3_sing_reg ? ONE_W : f3_r_reg[0]);
        res.r01      = ext64(f3_sing_reg ? '0 : f3_r_reg[1]);
        res.r02      = ext64(f3_sing_reg ? '0 : f3_r_reg[2]);
        res.r10      = ext64(f3_sing_reg ? '0 : f3_r_reg[3]);
        res.r11      = ext64(f3_sing_reg ? ONE_W : f3_r_reg[4]);
        res.r12      = ext64(f3_sing_reg ? '0 : f3_r_reg[5]);
        res.r20      = ext64(f3_sing_reg ? '0 : f3_r_reg[6]);
        res.r21      = ext64(f3_sing_reg ? '0 : f3_r_reg[7]);
        res.r22      = ext64(f3_sing_reg ? ONE_W : f3_r_reg[8]);
        res.singular = f3_sing_reg;
        res.overflow = !f3_sing_reg && f3_ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NV-2:0], mat_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            in_m_reg    <= in_m_next;
            c1_pp_reg   <= c1_pp_next;
            c2_sum_reg  <= c2_sum_next;
            c3_p_reg    <= c3_p_next;
            c3_ovf_reg  <= c3_ovf_next;
            c4_a_reg    <= c4_a_next;
            c4_ovf_reg  <= c4_ovf_next;
            for (int k = 0; k < 3; k++) begin
                c1_m_reg[k] <= in_m_reg[k];
                c2_m_reg[k] <= c1_m_reg[k];
                c3_m_reg[k] <= c2_m_reg[k];
                c4_m_reg[k] <= c3_m_reg[k];
            end
            d1_pp_reg   <= d1_pp_next;
            d1_a_reg    <= c4_a_reg;
            d1_ovf_reg  <= c4_ovf_reg;
            d2_sum_reg  <= d2_sum_next;
            d2_a_reg    <= d1_a_reg;
            d2_ovf_reg  <= d1_ovf_reg;
            d3_p_reg    <= d3_p_next;
            d3_a_reg    <= d2_a_reg;
            d3_ovf_reg  <= d3_ovf_next;
            d4_s01_reg  <= d4_s01_next;
            d4_p2_reg   <= d3_p_reg[2];
            d4_a_reg    <= d3_a_reg;
            d4_ovf_reg  <= d4_ovf_next;
            d5_det_reg  <= d5_det_next;
            d5_a_reg    <= d4_a_reg;
            d5_ovf_reg  <= d5_ovf_next;
            for (int j = 0; j <= QW; j++) begin
                dv_reg[j] <= dv_next[j];
            end
            rc_inv_reg  <= rc_inv_next;
            rc_a_reg    <= rc_a_next;
            rc_ovf_reg  <= rc_ovf_next;
            rc_sing_reg <= dv_reg[QW].sing;
            f1_pp_reg   <= f1_pp_next;
            f1_ovf_reg  <= rc_ovf_reg;
            f1_sing_reg <= rc_sing_reg;
            f2_sum_reg  <= f2_sum_next;
            f2_ovf_reg  <= f1_ovf_reg;
            f2_sing_reg <= f1_sing_reg;
            f3_r_reg    <= f3_r_next;
            f3_ovf_reg  <= f3_ovf_next;
            f3_sing_reg <= f2_sing_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (take) begin
                skid_v_reg <= 1'b0;
            end
        end else if (vld_reg[NV-1]) begin
            if (!out_v_reg || take) begin
                out_v_reg <= 1'b1;
            end else begin
                skid_v_reg <= 1'b1;
            end
        end else if (take) begin
            out_v_reg <= 1'b0;
        end
    end

    // hold the stalled beat, park the next one in skid
    always_ff @(posedge clk)
    begin
        if (skid_v_reg) begin
            if (take) begin
                out_reg <= skid_reg;
            end
        end else if (vld_reg[NV-1]) begin
            if (!out_v_reg || take) begin
                out_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end
    end

endmodule

`default_nettype wire
